>>> rtl/indexed_list_insert_delete_macros.svh
// Assertion macros for the indexed list block.
// Included by files that carry concurrent checks; needs clk and rst_n in scope.
`ifndef INDEXED_LIST_INSERT_DELETE_MACROS_SVH
`define INDEXED_LIST_INSERT_DELETE_MACROS_SVH

`ifndef SYNTHESIS
`define ILID_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ILID_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ILID_ASSERT(label, prop, msg)
`define ILID_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

>>> rtl/ilid_pkg.sv
// Shared types and constants for the indexed list block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ilid_pkg;

  localparam int CAP_DEF = 64;
  localparam int CAP_MAX = 1024;
  localparam int POS_W   = $clog2(CAP_MAX + 1);
  localparam int DATA_W  = 32;
  localparam int IDX_W   = 7;
  localparam int CNT_W   = 7;
  localparam int GRP     = 32;

  typedef enum logic [2:0] {
    FN_READ = 3'd0,
    FN_HEAD = 3'd1,
    FN_TAIL = 3'd2,
    FN_AT   = 3'd3,
    FN_DEL  = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } stat_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_FIN
  } state_t;

  typedef struct packed {
    func_t                     func;
    logic [IDX_W-1:0]          index;
    logic signed [DATA_W-1:0]  value;
  } in_req_t;

  typedef struct packed {
    stat_t                     status;
    logic signed [DATA_W-1:0]  read_value;
    logic [CNT_W-1:0]          count;
  } out_rsp_t;

  typedef struct packed {
    logic              ins;
    logic              del;
    logic              rd;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] value;
  } cell_ctl_t;

endpackage

>>> rtl/ilid_cell.sv
// One list position: holds an entry and shifts toward either neighbor.
// Depends on ilid_pkg for the control struct and widths.
`timescale 1ns / 1ps

module ilid_cell import ilid_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  cell_ctl_t         ctl_i,
  input  logic [DATA_W-1:0] left_i,
  input  logic [DATA_W-1:0] right_i,
  output logic [DATA_W-1:0] data_o,
  output logic [DATA_W-1:0] rd_o
);

  localparam logic [POS_W-1:0] IDX_P = POS_W'(IDX);

  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctl_i.ins) begin
      if (IDX_P == ctl_i.pos) begin
        data_nxt = ctl_i.value;
      end else if (IDX_P > ctl_i.pos) begin
        data_nxt = left_i;
      end
    end else if (ctl_i.del && IDX_P >= ctl_i.pos) begin
      data_nxt = right_i;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;
  assign rd_o   = (ctl_i.rd && IDX_P == ctl_i.pos) ? data_r : '0;

endmodule

>>> rtl/ilid_reduce.sv
// Two-level OR gather of the per-cell read taps: registered groups, then a final OR.
// Depends on ilid_pkg for the group size and data width.
`timescale 1ns / 1ps

module ilid_reduce import ilid_pkg::*; #(
  parameter int CAPACITY = CAP_DEF
) (
  input  logic              clk,
  input  logic              load_i,
  input  logic [DATA_W-1:0] tap_i [CAPACITY],
  output logic [DATA_W-1:0] data_o
);

  localparam int NG = (CAPACITY + GRP - 1) / GRP;

  logic [DATA_W-1:0] grp_r   [NG];
  logic [DATA_W-1:0] grp_nxt [NG];

  for (genvar g = 0; g < NG; g++) begin : g_grp
    localparam int LO = g * GRP;
    localparam int N  = (CAPACITY - LO < GRP) ? (CAPACITY - LO) : GRP;

    always_comb begin
      grp_nxt[g] = '0;
      for (int k = 0; k < N; k++) begin
        grp_nxt[g] = grp_nxt[g] | tap_i[LO + k];
      end
    end

    always_ff @(posedge clk) begin
      if (load_i) begin
        grp_r[g] <= grp_nxt[g];
      end
    end
  end

  always_comb begin
    data_o = '0;
    for (int g = 0; g < NG; g++) begin
      data_o = data_o | grp_r[g];
    end
  end

endmodule

>>> rtl/indexed_list_insert_delete.sv
// Indexed list top level: sequencer, row of ilid_cell, ilid_reduce gather, output register.
// Depends on ilid_pkg and indexed_list_insert_delete_macros.svh.
`timescale 1ns / 1ps
`include "indexed_list_insert_delete_macros.svh"

// Ordered list of up to CAPACITY signed 32-bit values held in a row of cells. Each request
// (read, insert at head, insert at tail, insert before index, delete at index) is accepted
// in the idle step; in the execute step every cell compares its position to the request
// index and shifts or loads in the same edge while the read taps land in registered groups
// of 32; in the final step the groups are ORed into the output register once the result
// side is free. A result waits in the output register while the next request is accepted; a
// stalled output holds the sequencer in its final step. Status reports an out-of-range
// index or a full list (insert dropped); count is the low 7 bits of the entry count after
// the request. Entries need no clearing after reset.
module indexed_list_insert_delete import ilid_pkg::*; #(
  parameter int CAPACITY = CAP_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_req_t  in_req,
  output logic     out_valid,
  input  logic     out_stall,
  output out_rsp_t out_rsp
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [POS_W-1:0] CAP_P = POS_W'(CAPACITY);

  state_t           state_r, state_nxt;
  in_req_t          req_r;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  stat_t            status_r, status_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_rsp_t         out_r;
  logic             out_ld;
  cell_ctl_t        ctl;
  logic [POS_W-1:0] pos_e;
  logic [POS_W-1:0] cnt_e;
  logic [POS_W-1:0] ins_pos;
  logic             is_ins;
  logic [DATA_W-1:0] rd_data;

  logic [DATA_W-1:0] cell_data [CAPACITY];
  logic [DATA_W-1:0] cell_tap  [CAPACITY];

  assign pos_e = POS_W'(req_r.index);
  assign cnt_e = POS_W'(cnt_r);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r;
    out_ld        = 1'b0;
    is_ins        = 1'b0;
    ins_pos       = pos_e;
    ctl.ins       = 1'b0;
    ctl.del       = 1'b0;
    ctl.rd        = 1'b0;
    ctl.value     = req_r.value;

    case (req_r.func)
      FN_HEAD: begin
        is_ins  = 1'b1;
        ins_pos = '0;
      end
      FN_TAIL: begin
        is_ins  = 1'b1;
        ins_pos = cnt_e;
      end
      FN_AT: begin
        is_ins  = 1'b1;
      end
      default: begin
        ins_pos = pos_e;
      end
    endcase
    ctl.pos = ins_pos;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        status_nxt = ST_DONE;
        state_nxt  = S_FIN;
        if (is_ins) begin
          if (ins_pos > cnt_e) begin
            status_nxt = ST_RANGE;
          end else if (cnt_e == CAP_P) begin
            status_nxt = ST_FULL;
          end else begin
            ctl.ins = 1'b1;
            cnt_nxt = cnt_r + CW'(1);
          end
        end else begin
          case (req_r.func)
            FN_READ: begin
              if (pos_e < cnt_e) begin
                ctl.rd = 1'b1;
              end else begin
                status_nxt = ST_RANGE;
              end
            end
            FN_DEL: begin
              if (pos_e < cnt_e) begin
                ctl.del = 1'b1;
                cnt_nxt = cnt_r - CW'(1);
              end else begin
                status_nxt = ST_RANGE;
              end
            end
            default: begin
              status_nxt = ST_DONE;
            end
          endcase
        end
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_ld        = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      req_r <= in_req;
    end
    status_r <= status_nxt;
    if (out_ld) begin
      out_r.status     <= status_r;
      out_r.read_value <= rd_data;
      out_r.count      <= CNT_W'(cnt_r);
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left_w;
    logic [DATA_W-1:0] right_w;

    if (i == 0) begin : g_first
      assign left_w = ctl.value;
    end else begin : g_mid_l
      assign left_w = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_w = cell_data[i];
    end else begin : g_mid_r
      assign right_w = cell_data[i+1];
    end

    ilid_cell #(
      .IDX (i)
    ) u_cell (
      .clk     (clk),
      .ctl_i   (ctl),
      .left_i  (left_w),
      .right_i (right_w),
      .data_o  (cell_data[i]),
      .rd_o    (cell_tap[i])
    );
  end

  ilid_reduce #(
    .CAPACITY (CAPACITY)
  ) u_reduce (
    .clk    (clk),
    .load_i (state_r == S_EXEC),
    .tap_i  (cell_tap),
    .data_o (rd_data)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_r;

  `ILID_ASSERT(a_cnt_bound, cnt_r <= CW'(CAPACITY), "entry count above capacity")
  `ILID_ASSERT_NEXT(a_accept_exec, in_valid && !in_stall, state_r == S_EXEC, "accept did not start execution")
  `ILID_ASSERT_NEXT(a_cnt_hold, state_r != S_EXEC, $stable(cnt_r), "count moved outside execution")
  `ILID_ASSERT(a_full_cnt, (state_r == S_FIN && status_r == ST_FULL) |-> cnt_r == CW'(CAPACITY), "full status with room left")
  `ILID_ASSERT(a_out_src, $rose(out_valid_r) |-> $past(state_r) == S_FIN, "result raised outside final step")

endmodule
